[rtl/fehu_pkg.sv]
// Shared types and constants for the front-end hit unpacker.
`timescale 1ns / 1ps

package fehu_pkg;

  localparam int              SLICE_HEADER_BYTES_DEF = 16;
  localparam int              ALIGN_BYTES_DEF        = 8;
  localparam longint unsigned MAX_SLICE_BYTES_DEF    = 64'd65536;

  // Entries in the queue between parser and record builder.
  localparam int QUEUE_DEPTH = 4;

  // Message type codes (low nibble of message byte 5).
  localparam logic [3:0] MSG_TYPE_HIT   = 4'h1;
  localparam logic [3:0] MSG_TYPE_EPOCH = 4'h2;

  // Bytes of a message held before the closing byte arrives.
  localparam int MSG_HELD_BYTES = 5;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        slice_start;
    logic [15:0] slice_equipment;
  } in_word_t;

  typedef struct packed {
    logic [15:0] equipment_id;
    logic [17:0] chip_address;
    logic [6:0]  channel;
    logic [31:0] hit_epoch;
    logic [13:0] timestamp;
    logic [11:0] adc_value;
    logic        last_epoch_flag;
  } out_word_t;

  // One classified message handed from parser to record builder.
  typedef struct packed {
    logic                               is_epoch;
    logic [MSG_HELD_BYTES-1:0][7:0]     msg;
    logic [7:0]                         last_byte;
    logic [15:0]                        source_id;
    logic [15:0]                        equipment;
  } qentry_t;

endpackage

[rtl/fehu_front.sv]
// Byte parser: slice header skip, packet headers, message assembly, padding.
`timescale 1ns / 1ps

module fehu_front #(
  parameter int              SLICE_HEADER_BYTES = fehu_pkg::SLICE_HEADER_BYTES_DEF,
  parameter int              ALIGN_BYTES        = fehu_pkg::ALIGN_BYTES_DEF,
  parameter longint unsigned MAX_SLICE_BYTES    = fehu_pkg::MAX_SLICE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  fehu_pkg::in_word_t byte_word,
  output logic               q_push,
  output fehu_pkg::qentry_t  q_entry,
  input  logic               q_full
);

  localparam int POS_W   = $clog2(MAX_SLICE_BYTES + 64'd1);
  localparam int CMP_W   = (POS_W > 9) ? POS_W : 9;
  localparam int ALIGN_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam int MCNT_W  = $clog2(fehu_pkg::MSG_HELD_BYTES + 1);

  typedef enum logic [1:0] {PH_SKIP, PH_HDR, PH_MSG, PH_PAD} phase_t;

  phase_t               phase, ph_next;
  logic [POS_W-1:0]     position, position_next, pos_cur;
  logic [ALIGN_W-1:0]   align_cnt, align_next, align_cur;
  logic [7:0]           words, words_next;
  logic [9:0]           pbi, pbi_next, pbi_inc;
  logic [15:0]          src, src_next;
  logic [MCNT_W-1:0]    mcnt, mcnt_next;
  logic [fehu_pkg::MSG_HELD_BYTES-1:0][7:0] msg;
  logic                 msg_wr;
  logic                 accept, past_end, in_header, align_last, live, push_next;
  logic [3:0]           msg_type;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = q_full;
  assign msg_type   = byte_word.data_byte[3:0];
  assign past_end   = CMP_W'(pos_cur) >= CMP_W'(MAX_SLICE_BYTES);
  assign in_header  = CMP_W'(pos_cur) < CMP_W'(SLICE_HEADER_BYTES);
  assign align_last = align_cur == ALIGN_W'(ALIGN_BYTES - 1);

  always_comb begin
    pos_cur       = byte_word.slice_start ? '0 : position;
    ph_next       = byte_word.slice_start ? PH_SKIP : phase;
    pbi_next      = byte_word.slice_start ? '0 : pbi;
    mcnt_next     = byte_word.slice_start ? '0 : mcnt;
    align_cur     = byte_word.slice_start ? '0 : align_cnt;
    position_next = pos_cur;
    align_next    = align_cur;
    words_next    = words;
    src_next      = src;
    pbi_inc       = '0;
    live          = 1'b0;
    msg_wr        = 1'b0;
    push_next     = 1'b0;
    if (!past_end) begin
      position_next = pos_cur + POS_W'(1);
      align_next    = align_last ? '0 : align_cur + ALIGN_W'(1);
      live          = 1'b1;
      if (ph_next == PH_SKIP) begin
        if (in_header) begin
          live = 1'b0;
        end else begin
          ph_next  = PH_HDR;
          pbi_next = '0;
        end
      end
      if (ph_next == PH_PAD) begin
        if (align_cur != '0) begin
          live = 1'b0;
        end else begin
          ph_next  = PH_HDR;
          pbi_next = '0;
        end
      end
      if (live) begin
        pbi_inc = pbi_next + 10'd1;
        if (ph_next == PH_HDR) begin
          case (pbi_next[1:0])
            2'd0:    words_next = byte_word.data_byte;
            2'd1:    words_next = words;
            2'd2:    src_next   = {8'h00, byte_word.data_byte};
            default: src_next   = {byte_word.data_byte, src[7:0]};
          endcase
          pbi_next = pbi_inc;
          if (pbi_inc == 10'd4) begin
            if (words_next == 8'd0) begin
              ph_next   = align_last ? PH_HDR : PH_PAD;
              pbi_next  = '0;
              mcnt_next = '0;
            end else begin
              ph_next   = PH_MSG;
              mcnt_next = '0;
            end
          end
        end else begin
          if (mcnt_next < MCNT_W'(fehu_pkg::MSG_HELD_BYTES)) begin
            msg_wr    = 1'b1;
            mcnt_next = mcnt_next + MCNT_W'(1);
          end else begin
            mcnt_next = '0;
            push_next = msg_type inside {fehu_pkg::MSG_TYPE_HIT, fehu_pkg::MSG_TYPE_EPOCH};
          end
          pbi_next = pbi_inc;
          if (pbi_inc >= ({1'b0, words, 1'b0} + 10'd4)) begin
            ph_next   = align_last ? PH_HDR : PH_PAD;
            pbi_next  = '0;
            mcnt_next = '0;
          end
        end
      end
    end
  end

  // Entry fields come from held bytes, the packet's source id and the closing byte's word on the bus.
  assign q_push            = accept && push_next;
  assign q_entry.is_epoch  = (msg_type == fehu_pkg::MSG_TYPE_EPOCH);
  assign q_entry.msg       = msg;
  assign q_entry.last_byte = byte_word.data_byte;
  assign q_entry.source_id = src;
  assign q_entry.equipment = byte_word.slice_equipment;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SKIP;
      position  <= '0;
      align_cnt <= '0;
      words     <= '0;
      pbi       <= '0;
      src       <= '0;
      mcnt      <= '0;
    end else if (accept) begin
      phase     <= ph_next;
      position  <= position_next;
      align_cnt <= align_next;
      words     <= words_next;
      pbi       <= pbi_next;
      src       <= src_next;
      mcnt      <= mcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && msg_wr) begin
      msg[mcnt_next - MCNT_W'(1)] <= byte_word.data_byte;
    end
  end

  a_mcnt_range: assert property (@(posedge clk) disable iff (rst)
    mcnt <= MCNT_W'(fehu_pkg::MSG_HELD_BYTES))
    else $error("message byte count out of range");

  a_push_only_in_msg: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (phase == PH_MSG) && !byte_word.slice_start)
    else $error("queue push outside message phase");

endmodule

[rtl/fehu_queue.sv]
// Short queue of classified messages between parser and record builder.
`timescale 1ns / 1ps

module fehu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fehu_pkg::qentry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output fehu_pkg::qentry_t head_entry
);

  localparam int DEPTH = fehu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fehu_pkg::qentry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

[rtl/fehu_back.sv]
// Record builder: epoch register and registered hit output.
`timescale 1ns / 1ps

module fehu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  fehu_pkg::qentry_t   head_entry,
  output logic                pop,
  output logic                hit_valid,
  input  logic                hit_stall,
  output fehu_pkg::out_word_t hit_word
);

  logic [31:0] epoch;
  logic        out_free, last_flag;

  assign out_free  = !hit_valid || !hit_stall;
  assign pop       = head_valid && (head_entry.is_epoch || out_free);
  assign last_flag = head_entry.msg[0][7];

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= '0;
      hit_valid <= 1'b0;
    end else begin
      if (pop && head_entry.is_epoch) begin
        epoch <= {head_entry.msg[1], head_entry.msg[2], head_entry.msg[3], head_entry.msg[4]};
      end
      if (pop && !head_entry.is_epoch) begin
        hit_valid <= 1'b1;
      end else if (!hit_stall) begin
        hit_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head_entry.is_epoch) begin
      hit_word.equipment_id    <= head_entry.equipment;
      hit_word.chip_address    <= {head_entry.source_id, head_entry.last_byte[7:6]};
      hit_word.channel         <= head_entry.msg[2][7:1];
      hit_word.hit_epoch       <= epoch - {31'd0, last_flag};
      hit_word.timestamp       <= {head_entry.msg[2][0], head_entry.msg[3],
                                   head_entry.msg[4][7:3]};
      hit_word.adc_value       <= {head_entry.msg[0][4:0], head_entry.msg[1][7:1]};
      hit_word.last_epoch_flag <= last_flag;
    end
  end

  a_epoch_src: assert property (@(posedge clk) disable iff (rst)
    !$stable(epoch) |-> $past(pop && head_entry.is_epoch))
    else $error("epoch changed without epoch message");

  a_hit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(hit_valid) |-> $past(pop && !head_entry.is_epoch))
    else $error("record appeared without hit message");

endmodule

[rtl/front_end_hit_unpacker.sv]
// Top level of the front-end hit unpacker: parser, message queue, record builder.
`timescale 1ns / 1ps

// Takes microslice content one byte per word and emits one record per hit
// message. Each slice (first byte flagged by slice_start) opens with
// SLICE_HEADER_BYTES skipped bytes, then packets: a 4-byte header (length in
// 16-bit words, counter, little-endian source id) and 6-byte messages. Type 1
// messages become hit records, type 2 messages load the big-endian epoch
// register (kept across slices), all other types and any partial trailing
// message are dropped. After a packet the parser skips to the next
// ALIGN_BYTES boundary counted from slice start; bytes at or past
// MAX_SLICE_BYTES are ignored. Rate: one byte per clock while byte_stall is
// low. The parser classifies each byte in the cycle it is taken and pushes
// finished type 1/2 messages into a 4-entry queue; the record builder drains
// one entry per clock, a hit only while the output is free (hits go to the
// output register, epochs to the epoch register), so a stalled output only
// backs up into the byte input once the queue is full. A hit's closing byte
// is written to a queue slot, then popped into the output register, raising hit_valid.

module front_end_hit_unpacker #(
  parameter int              SLICE_HEADER_BYTES = fehu_pkg::SLICE_HEADER_BYTES_DEF,
  parameter int              ALIGN_BYTES        = fehu_pkg::ALIGN_BYTES_DEF,
  parameter longint unsigned MAX_SLICE_BYTES    = fehu_pkg::MAX_SLICE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  fehu_pkg::in_word_t  byte_word,
  output logic                hit_valid,
  input  logic                hit_stall,
  output fehu_pkg::out_word_t hit_word
);

  // parser -> queue
  logic              q_push, q_full;
  fehu_pkg::qentry_t q_entry;

  // queue -> builder
  logic              q_pop, head_valid;
  fehu_pkg::qentry_t head_entry;

  fehu_front #(
    .SLICE_HEADER_BYTES (SLICE_HEADER_BYTES),
    .ALIGN_BYTES        (ALIGN_BYTES),
    .MAX_SLICE_BYTES    (MAX_SLICE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .q_push     (q_push),
    .q_entry    (q_entry),
    .q_full     (q_full)
  );

  fehu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // epoch updates and hits leave the queue in stream order
  fehu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .hit_valid  (hit_valid),
    .hit_stall  (hit_stall),
    .hit_word   (hit_word)
  );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for front_end_hit_unpacker: byte stream in, hit records out.
`timescale 1ns / 1ps

module tb_top;

  // Generous bound; a correct run with the longest output stalls needs only a
  // small fraction of this.
  localparam int CYCLE_LIMIT = 50_000;
  localparam int RANDOM_BYTES = 1550;

  // ---------------------------------------------------------------------------
  // Scoreboard: tracks the parser state of the unpacker byte by byte and keeps
  // the hit records still owed by the block, oldest first.
  // ---------------------------------------------------------------------------
  class hit_scoreboard;
    typedef enum logic [1:0] {SKIP_HDR, PKT_HDR, PKT_MSG, PKT_PAD} parse_t;

    int unsigned slice_pos;
    parse_t      phase;
    logic [7:0]  pkt_words;
    logic [9:0]  byte_idx;
    logic [15:0] src_id;
    logic [7:0]  held [fehu_pkg::MSG_HELD_BYTES];
    int unsigned held_cnt;
    logic [31:0] epoch;

    fehu_pkg::out_word_t owed_hits [$];
    int          errors;
    int          hits_checked;
    int          epoch_loads;

    function new();
      slice_pos    = 0;
      phase        = SKIP_HDR;
      pkt_words    = '0;
      byte_idx     = '0;
      src_id       = '0;
      held_cnt     = 0;
      epoch        = '0;
      errors       = 0;
      hits_checked = 0;
      epoch_loads  = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function int pending();
      return owed_hits.size();
    endfunction

    // Packet done: go straight to the next header if already aligned.
    function void close_packet(int unsigned p);
      phase    = ((p + 1) % fehu_pkg::ALIGN_BYTES_DEF == 0) ? PKT_HDR : PKT_PAD;
      byte_idx = '0;
      held_cnt = 0;
    endfunction

    function void note_byte(fehu_pkg::in_word_t w);
      int unsigned         p;
      logic [7:0]          b;
      fehu_pkg::out_word_t rec;
      b = w.data_byte;
      if (w.slice_start) begin
        slice_pos = 0;
        phase     = SKIP_HDR;
        byte_idx  = '0;
        held_cnt  = 0;
      end
      p = slice_pos;
      if (p >= fehu_pkg::MAX_SLICE_BYTES_DEF) return;
      slice_pos = p + 1;

      if (phase == SKIP_HDR) begin
        if (p < fehu_pkg::SLICE_HEADER_BYTES_DEF) return;
        phase    = PKT_HDR;
        byte_idx = '0;
      end
      if (phase == PKT_PAD) begin
        if (p % fehu_pkg::ALIGN_BYTES_DEF != 0) return;
        phase    = PKT_HDR;
        byte_idx = '0;
      end

      if (phase == PKT_HDR) begin
        case (byte_idx[1:0])
          2'd0: pkt_words = b;
          2'd2: src_id = {8'h00, b};
          2'd3: src_id[15:8] = b;
          default: ;
        endcase
        byte_idx = byte_idx + 10'd1;
        if (byte_idx == 10'd4) begin
          if (pkt_words == 8'd0) begin
            close_packet(p);
          end else begin
            phase    = PKT_MSG;
            held_cnt = 0;
          end
        end
        return;
      end

      // message body
      if (held_cnt < fehu_pkg::MSG_HELD_BYTES) begin
        held[held_cnt] = b;
        held_cnt++;
      end else begin
        held_cnt = 0;
        if (b[3:0] == fehu_pkg::MSG_TYPE_HIT) begin
          rec.equipment_id    = w.slice_equipment;
          rec.chip_address    = {src_id, b[7:6]};
          rec.channel         = held[2][7:1];
          rec.last_epoch_flag = held[0][7];
          rec.hit_epoch       = epoch - {31'd0, held[0][7]};
          rec.timestamp       = {held[2][0], held[3], held[4][7:3]};
          rec.adc_value       = {held[0][4:0], held[1][7:1]};
          owed_hits.push_back(rec);
        end else if (b[3:0] == fehu_pkg::MSG_TYPE_EPOCH) begin
          epoch = {held[1], held[2], held[3], held[4]};
          epoch_loads++;
        end
      end
      byte_idx = byte_idx + 10'd1;
      if (byte_idx >= {1'b0, pkt_words, 1'b0} + 10'd4) close_packet(p);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_hit(fehu_pkg::out_word_t got);
      fehu_pkg::out_word_t want;
      if (owed_hits.size() == 0) begin
        $error("hit record with none owed: 0x%0h", got);
        errors++;
        return;
      end
      want = owed_hits.pop_front();
      hits_checked++;
      cmp_field("equipment_id", 32'(want.equipment_id), 32'(got.equipment_id));
      cmp_field("chip_address", 32'(want.chip_address), 32'(got.chip_address));
      cmp_field("channel", 32'(want.channel), 32'(got.channel));
      cmp_field("hit_epoch", want.hit_epoch, got.hit_epoch);
      cmp_field("timestamp", 32'(want.timestamp), 32'(got.timestamp));
      cmp_field("adc_value", 32'(want.adc_value), 32'(got.adc_value));
      cmp_field("last_epoch_flag", 32'(want.last_epoch_flag), 32'(got.last_epoch_flag));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  fehu_pkg::in_word_t  byte_word  = '0;
  logic                hit_valid;
  logic                hit_stall  = 1'b0;
  fehu_pkg::out_word_t hit_word;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  front_end_hit_unpacker u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_word (byte_word),
    .hit_valid (hit_valid),
    .hit_stall (hit_stall),
    .hit_word  (hit_word)
  );

  hit_scoreboard sb = new();

  // Stimulus bookkeeping
  logic        calm      = 1'b0;  // no idling on either side while set
  logic [15:0] equip_now = '0;    // equipment id sent with every byte
  int          gen_pos   = 0;     // position inside the slice being sent
  int          bytes_sent = 0;
  int          slices_sent = 0;
  int          pkts_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  body_q [$];        // message bytes of the packet being built

  // ---------------------------------------------------------------------------
  // Output side: random stalls, single cycles plus the odd long burst so the
  // internal queue fills and pushes back on the byte input.
  // ---------------------------------------------------------------------------
  int stall_burst = 0;

  always @(posedge clk) begin
    if (calm) begin
      hit_stall   <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst != 0) begin
      hit_stall   <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if ($urandom_range(0, 249) == 0) begin
      hit_stall   <= 1'b1;
      stall_burst <= int'($urandom_range(4, 24));
    end else begin
      hit_stall   <= ($urandom_range(0, 99) < 8);
    end
  end

  // Both channels are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) sb.note_byte(byte_word);
    if (!rst && hit_valid && !hit_stall) sb.check_hit(hit_word);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver. valid stays high from one word to the next unless idle
  // cycles are inserted; a stalled word is held unchanged.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] data, input logic first);
    fehu_pkg::in_word_t w;
    w.data_byte       = data;
    w.slice_start     = first;
    w.slice_equipment = equip_now;
    if (!calm && $urandom_range(0, 99) < 8) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    byte_word  <= w;
    byte_valid <= 1'b1;
    do @(posedge clk); while (byte_stall);
    gen_pos++;
    bytes_sent++;
  endtask

  // Stop sending and hold off until every owed record has come out.
  task automatic wait_all_hits();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Slice header: first byte optionally flagged, rest skipped by the block.
  task automatic start_slice(input logic flagged);
    logic [31:0] r;
    r = $urandom;
    case (r[3:0])
      4'd0:    equip_now = 16'h0000;
      4'd1:    equip_now = 16'hFFFF;
      default: equip_now = r[31:16];
    endcase
    gen_pos = 0;
    slices_sent++;
    push_byte(8'($urandom), flagged);
    repeat (fehu_pkg::SLICE_HEADER_BYTES_DEF - 1) push_byte(8'($urandom), 1'b0);
  endtask

  // Hit message; pileup/overflow and spare bits are random.
  function automatic void add_hit(logic last, logic [11:0] adc, logic [6:0] chan,
                                  logic [13:0] ts, logic [1:0] chip);
    logic [31:0] r;
    r = $urandom;
    body_q.push_back({last, r[1:0], adc[11:7]});
    body_q.push_back({adc[6:0], r[2]});
    body_q.push_back({chan, ts[13]});
    body_q.push_back(ts[12:5]);
    body_q.push_back({ts[4:0], r[5:3]});
    body_q.push_back({chip, r[7:6], fehu_pkg::MSG_TYPE_HIT});
  endfunction

  function automatic void add_random_hit();
    logic [31:0] r;
    r = $urandom;
    add_hit(r[0], r[12:1], r[19:13], 14'($urandom), r[21:20]);
  endfunction

  // Epoch message, big-endian value in bytes 1..4.
  function automatic void add_epoch(logic [31:0] e);
    logic [31:0] r;
    r = $urandom;
    body_q.push_back(r[7:0]);
    body_q.push_back(e[31:24]);
    body_q.push_back(e[23:16]);
    body_q.push_back(e[15:8]);
    body_q.push_back(e[7:0]);
    body_q.push_back({r[11:8], fehu_pkg::MSG_TYPE_EPOCH});
  endfunction

  // Message of a type the block drops.
  function automatic void add_other(logic [3:0] kind);
    logic [31:0] r;
    r = $urandom;
    body_q.push_back(r[7:0]);
    body_q.push_back(r[15:8]);
    body_q.push_back(r[23:16]);
    body_q.push_back(r[31:24]);
    body_q.push_back(8'($urandom));
    body_q.push_back({r[3:0] ^ r[7:4], kind});
  endfunction

  function automatic void add_random_msg();
    int          pick;
    int          kind;
    logic [31:0] e;
    pick = int'($urandom_range(0, 99));
    if (pick < 55) begin
      add_random_hit();
    end else if (pick < 70) begin
      e = $urandom;
      if (e[31:29] == 3'd0) e = 32'h0000_0000;
      else if (e[31:29] == 3'd1) e = 32'hFFFF_FFFF;
      add_epoch(e);
    end else begin
      kind = int'($urandom_range(0, 13));
      if (kind >= 1) kind += 2;  // skip the hit and epoch codes
      add_other(4'(kind));
    end
  endfunction

  // Sends header plus body_q; cut >= 0 abandons the packet after that many
  // bytes (slice ends inside it), otherwise pads to the next alignment point.
  task automatic emit_packet(input logic [15:0] src, input int cut);
    logic [7:0] hdr [4];
    int         total;
    if (body_q.size() % 2 != 0) body_q.push_back(8'($urandom));
    hdr[0] = 8'(body_q.size() / 2);
    hdr[1] = 8'($urandom);
    hdr[2] = src[7:0];
    hdr[3] = src[15:8];
    total  = 4 + body_q.size();
    for (int k = 0; k < total; k++) begin
      if (cut >= 0 && k >= cut) break;
      push_byte((k < 4) ? hdr[k] : body_q[k - 4], 1'b0);
    end
    body_q.delete();
    if (cut < 0) begin
      while (gen_pos % fehu_pkg::ALIGN_BYTES_DEF != 0) push_byte(8'($urandom), 1'b0);
    end
    pkts_sent++;
  endtask

  // Well-formed packet with random content; length mostly small, rarely large.
  task automatic random_packet(input int cut);
    int          pick;
    int          nbytes;
    logic [31:0] r;
    logic [15:0] src;
    pick = int'($urandom_range(0, 99));
    if (pick < 8) nbytes = 0;
    else if (pick < 97) nbytes = 2 * int'($urandom_range(1, 15));
    else nbytes = 2 * int'($urandom_range(16, 255));
    while (body_q.size() + 6 <= nbytes) add_random_msg();
    while (body_q.size() < nbytes) body_q.push_back(8'($urandom));
    r = $urandom;
    if (r[3:0] == 4'd0) src = 16'h0000;
    else if (r[3:0] == 4'd1) src = 16'hFFFF;
    else src = r[31:16];
    emit_packet(src, cut);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    int npk;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // Stream opens with no slice start flag: the block must behave as if a
    // slice had just begun.
    equip_now = 16'hFFFF;
    gen_pos   = 0;
    slices_sent++;
    repeat (fehu_pkg::SLICE_HEADER_BYTES_DEF) push_byte(8'($urandom), 1'b0);
    add_hit(1'b0, 12'hFFF, 7'h7F, 14'h3FFF, 2'd3);  // all-ones fields, epoch zero
    add_hit(1'b1, 12'h000, 7'h00, 14'h0000, 2'd0);  // last-epoch at zero wraps
    add_epoch(32'hFFFF_FFFF);
    add_hit(1'b0, 12'h800, 7'h40, 14'h2000, 2'd2);
    add_hit(1'b1, 12'h001, 7'h01, 14'h0001, 2'd1);
    add_other(4'h0);
    add_other(4'h3);
    add_other(4'hF);
    body_q.push_back(8'hFF);  // partial trailing message
    body_q.push_back(8'h01);
    emit_packet(16'hFFFF, -1);
    emit_packet(16'h0000, -1);  // zero-length packet
    add_epoch(32'h8000_0001);
    add_hit(1'b1, 12'h555, 7'h2A, 14'h1555, 2'd1);
    emit_packet(16'h0000, -1);

    // Slice ends mid-packet, inside a hit message.
    add_random_hit();
    add_random_hit();
    emit_packet(16'hA5C3, 9);
    start_slice(1'b1);
    equip_now = 16'h0000;
    add_epoch(32'h0000_0000);
    add_hit(1'b0, 12'hAAA, 7'h55, 14'h2AAA, 2'd2);
    emit_packet(16'h5A3C, -1);

    // --- random ---
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      // one stretch of slices with no idling anywhere
      calm = (slices_sent >= 6 && slices_sent < 10);
      if (slices_sent == 5) wait_all_hits();
      // a rare missing slice flag leaves the packet parse misaligned
      start_slice($urandom_range(0, 99) >= 3);
      npk = int'($urandom_range(1, 5));
      for (int i = 0; i < npk; i++) begin
        if ($urandom_range(0, 99) < 6) begin
          random_packet(int'($urandom_range(1, 24)));
          break;
        end
        random_packet(-1);
      end
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 30)) push_byte(8'($urandom), 1'b0);
      end
    end
    calm = 1'b0;

    // Clean slice after the random stretch.
    start_slice(1'b1);
    add_random_hit();
    add_random_hit();
    emit_packet(16'h1357, -1);

    wait_all_hits();
    repeat (16) @(posedge clk);

    $display("Run covered %0d bytes in %0d slices and %0d packets.",
             bytes_sent, slices_sent, pkts_sent);
    $display("%0d hit records checked, %0d epoch loads, %0d mismatches.",
             sb.hits_checked, sb.epoch_loads, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fehu_pkg.sv
rtl/fehu_front.sv
rtl/fehu_queue.sv
rtl/fehu_back.sv
rtl/front_end_hit_unpacker.sv
verif/tb_top.sv
